>>> hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int unsigned NumRounds = 64;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LenBytes = 56;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] RoundK [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// byte source for the block buffer write port
	typedef enum logic [1:0] {
		SRC_MSG  = 2'd0,
		SRC_PAD  = 2'd1,
		SRC_ZERO = 2'd2,
		SRC_LEN  = 2'd3
	} byte_src_t;

	// controller -> datapath
	typedef struct packed {
		logic      wr_en;       // write one byte into the block buffer
		byte_src_t wr_src;
		logic [5:0] wr_addr;
		logic      len_add;     // bit length += 8
		logic      len_clr;
		logic      rd_en;       // read buffer word
		logic [3:0] rd_word;
		logic      comp_init;   // load work vars from chain
		logic      round_en;    // run one round
		logic [5:0] round_idx;
		logic      sched_load;  // schedule word comes from buffer
		logic      chain_add;   // fold work vars into chain
		logic      chain_init;  // restore initial hash
		logic      out_load;    // load output register with word out_idx
		logic [2:0] out_idx;
	} sha_cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

>>> hdl/sha_ram.sv
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sha_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

>>> hdl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule, round unit, chaining state and bit length.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::sha_cmd_t cmd,
	input  logic [7:0]        msg_byte,
	output logic [31:0]       out_word
);
	import sha_pkg::*;

	logic [63:0] bitlen_q;
	logic [7:0]  wr_byte;
	logic [31:0] rd_data;
	logic [31:0] chain_q [8];
	logic [31:0] wv_q [8];
	logic [31:0] win_q [16];
	logic [31:0] w_cur, s0, s1, t1, t2;
	logic [31:0] e, a;
	logic [2:0]  lsel;

	// 32-bit word RAM, byte lanes written separately: four byte RAMs
	assign lsel = 3'd7 - cmd.wr_addr[2:0];
	always_comb begin
		wr_byte = 8'h00;
		unique case (cmd.wr_src)
			SRC_MSG:  wr_byte = msg_byte;
			SRC_PAD:  wr_byte = PadByte;
			SRC_ZERO: wr_byte = 8'h00;
			SRC_LEN:  wr_byte = bitlen_q[{lsel, 3'b000} +: 8];
			default:  wr_byte = 8'h00;
		endcase
	end

	for (genvar ln = 0; ln < 4; ln++) begin : g_lane
		sha_ram #(.Width(8), .Depth(16)) u_ram (
			.clk     (clk),
			.wr_en   (cmd.wr_en && (cmd.wr_addr[1:0] == 2'(ln))),
			.wr_addr (cmd.wr_addr[5:2]),
			.wr_data (wr_byte),
			.rd_en   (cmd.rd_en),
			.rd_addr (cmd.rd_word),
			.rd_data (rd_data[31-8*ln -: 8])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitlen_q <= '0;
		end else if (cmd.len_clr) begin
			bitlen_q <= '0;
		end else if (cmd.len_add) begin
			bitlen_q <= bitlen_q + 64'd8;
		end
	end

	// schedule: window shifts, newest at index 15
	assign s0 = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
	assign s1 = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
	assign w_cur = cmd.sched_load ? rd_data : (s1 + win_q[9] + s0 + win_q[0]);

	assign a = wv_q[0];
	assign e = wv_q[4];
	assign t1 = wv_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
		+ ((e & wv_q[5]) ^ (~e & wv_q[6])) + RoundK[cmd.round_idx] + w_cur;
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
		+ ((a & wv_q[1]) ^ (a & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.comp_init) begin
			wv_q <= chain_q;
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= w_cur;
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
		if (cmd.out_load) begin
			out_word <= chain_q[cmd.out_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= InitHash;
		end else if (cmd.chain_init) begin
			chain_q <= InitHash;
		end else if (cmd.chain_add) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + wv_q[i];
		end
	end
endmodule

>>> hdl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte fill, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              byte_valid,
	input  logic              last_item,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [2:0]        out_index,
	output sha_pkg::sha_cmd_t cmd
);
	import sha_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_COMP  = 7'b0000010,
		ST_PAD   = 7'b0000100,
		ST_FILL  = 7'b0001000,
		ST_LEN   = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_START = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [5:0] fill_q;     // next byte slot
	logic [6:0] rnd_q;      // round counter, 64 = fold
	logic       fin_q;      // pad byte still to be written after this block
	logic       zfill_q;    // pad went out; next block starts with zero fill
	logic       lenblk_q;   // compressing block that holds length
	logic [3:0] oi_q;       // output word counter, 8 = done
	logic       ov_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.wr_src = SRC_MSG;
		cmd.wr_addr = fill_q;
		cmd.round_idx = rnd_q[5:0];
		cmd.rd_word = rnd_q[3:0];
		cmd.out_idx = oi_q[2:0];
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_en = in_fire && byte_valid;
				cmd.len_add = in_fire && byte_valid;
				cmd.rd_word = 4'd0;
			end
			ST_START: begin
				cmd.comp_init = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_word = 4'd0;
			end
			ST_COMP: begin
				if (rnd_q[6]) begin
					cmd.chain_add = 1'b1;
				end else begin
					cmd.round_en = 1'b1;
					cmd.sched_load = (rnd_q < 7'd16);
					cmd.rd_en = 1'b1;
					cmd.rd_word = 4'(rnd_q + 7'd1);
				end
			end
			ST_PAD: begin
				cmd.wr_en = 1'b1;
				cmd.wr_src = SRC_PAD;
			end
			ST_FILL: begin
				cmd.wr_en = 1'b1;
				cmd.wr_src = SRC_ZERO;
			end
			ST_LEN: begin
				cmd.wr_en = 1'b1;
				cmd.wr_src = SRC_LEN;
			end
			ST_OUT: begin
				cmd.out_load = (!ov_q || out_ready) && !oi_q[3];
				cmd.chain_init = oi_q[3] && (!ov_q || out_ready);
				cmd.len_clr = cmd.chain_init;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			zfill_q <= 1'b0;
			lenblk_q <= 1'b0;
			oi_q <= '0;
			ov_q <= 1'b0;
			out_index <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						fin_q <= last_item;
						if (byte_valid) fill_q <= fill_q + 6'd1;
						if (byte_valid && fill_q == 6'd63) begin
							state_q <= ST_START;
						end else if (last_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_START: begin
					rnd_q <= '0;
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q[6]) begin
						if (lenblk_q) begin
							lenblk_q <= 1'b0;
							oi_q <= '0;
							state_q <= ST_OUT;
						end else if (zfill_q) begin
							zfill_q <= 1'b0;
							state_q <= ST_FILL;
						end else if (fin_q) begin
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PAD: begin
					fin_q <= 1'b0;
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						zfill_q <= 1'b1;
						state_q <= ST_START;
					end else if (fill_q == 6'(LenBytes - 1)) begin
						state_q <= ST_LEN;
					end else begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						zfill_q <= 1'b1;
						state_q <= ST_START;
					end else if (fill_q == 6'(LenBytes - 1)) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						fin_q <= 1'b0;
						lenblk_q <= 1'b1;
						state_q <= ST_START;
					end
				end
				ST_OUT: begin
					if (!ov_q || out_ready) begin
						if (oi_q[3]) begin
							ov_q <= 1'b0;
							fill_q <= '0;
							fin_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							ov_q <= 1'b1;
							out_index <= oi_q[2:0];
							oi_q <= oi_q + 4'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> hdl/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 over a byte stream; emits the eight digest words on the last request.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                      | tuser / tlast
//  s_axis  | in  | [7:0] msg_byte             | tuser = byte_valid, tlast = last_item
//  m_axis  | out | [31:0] digest_word         | tuser = word_index, tlast = digest_last
//
//  The 64th byte of a block starts a compression (one round a cycle through the
//  single round unit, plus load and fold). Finishing writes pad, zero and length
//  bytes one per cycle between compressions (up to two blocks), then streams
//  eight words, one per cycle when m_axis_tready is high. Input is held off
//  while a block compresses, padding is written or the digest drains.
//  Reset clears control, bit length and chaining state; the buffer needs none.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
	input  logic        s_axis_tuser,   // [0] byte_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);
	import sha_pkg::*;

	sha_cmd_t cmd;
	logic     in_fire;

	// a request is taken when both sides agree
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign m_axis_tlast = (m_axis_tuser == 3'd7);

	sha_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.byte_valid (s_axis_tuser),
		.last_item  (s_axis_tlast),
		.in_ready   (s_axis_tready),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_index  (m_axis_tuser),
		.cmd        (cmd)
	);

	sha_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.msg_byte (s_axis_tdata),
		.out_word (m_axis_tdata)
	);
endmodule

>>> verif/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both streams, computes the SHA-256 digest of each message on its own
// and compares every digest word with what the engine returns.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	logic [31:0]  chain [8];
	logic [7:0]   blk [64];
	int unsigned  fill;
	logic [63:0]  msg_bits;
	digest_word_t digest_q[$];

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		v = chain;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	// absorb one request; on last, pad and queue the eight words
	task automatic absorb(logic [7:0] b, logic has_byte, logic fin);
		digest_word_t dw;
		if (has_byte) begin
			blk[fill] = b;
			fill++;
			msg_bits += 64'd8;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		end
		if (!fin)
			return;
		blk[fill] = sha_pkg::PadByte;
		fill++;
		if (fill > 56) begin
			while (fill < 64) blk[fill++] = 8'h00;
			compress();
			fill = 0;
		end
		while (fill < 56) blk[fill++] = 8'h00;
		for (int i = 0; i < 8; i++)
			blk[56+i] = msg_bits[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			dw.word = chain[i];
			dw.idx = 3'(i);
			dw.last = (i == 7);
			digest_q.push_back(dw);
		end
		chain = sha_pkg::InitHash;
		fill = 0;
		msg_bits = '0;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		words_pending = 0;
		chain = sha_pkg::InitHash;
		fill = 0;
		msg_bits = '0;
	end

	always @(posedge clk) begin
		digest_word_t exp_w;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				absorb(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0)
					report("unexpected digest word", m_axis_tdata, 0);
				else begin
					exp_w = digest_q.pop_front();
					if (m_axis_tdata !== exp_w.word)
						report("digest_word", m_axis_tdata, exp_w.word);
					if (m_axis_tuser !== exp_w.idx)
						report("word_index", m_axis_tuser, exp_w.idx);
					if (m_axis_tlast !== exp_w.last)
						report("digest_last", m_axis_tlast, exp_w.last);
				end
			end
			words_pending = digest_q.size();
		end
	end
endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives byte messages of many lengths into the SHA-256 engine with random
// gaps and output stalls; the digest checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;   // [0] byte_valid
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [31:0] digest_word
	logic [2:0]  m_axis_tuser;          // [2:0] word_index
	logic        m_axis_tlast;

	int  fail_count, words_pending;
	int  idle_cycles = 0;
	bit  hold_sink = 1'b0;    // long receiver hold-off requested
	bit  stall_free = 1'b0;   // stretch with no receiver stalls

	always #6 clk = ~clk;

	sha256_hash_engine u_top (.*);

	sha256_digest_checker u_chk (.*);

	// watchdog: cycles without any accepted request on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver: own stall pattern, long hold-off on request
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				for (hold = 0; hold < 300; hold++) @(negedge clk);
				hold_sink = 1'b0;
			end
			m_axis_tready <= stall_free ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// offer one request and hold it until accepted; valid stays up for the next
	task automatic send(logic [7:0] b, logic has_byte, logic fin);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= has_byte;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// burst-style sender: random gaps between requests, sometimes none
	task automatic send_gap(logic [7:0] b, logic has_byte, logic fin, bit gaps);
		int g;
		if (gaps && $urandom_range(0, 3) == 0) begin
			g = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		send(b, has_byte, fin);
	endtask

	task automatic send_message(int len, bit gaps, bit byte_on_last);
		for (int i = 0; i < len; i++) begin
			// occasional bare requests are noise, ignored by the engine
			if ($urandom_range(0, 15) == 0)
				send_gap(8'($urandom), 1'b0, 1'b0, gaps);
			if (byte_on_last && i == len - 1)
				send_gap(8'($urandom), 1'b1, 1'b1, gaps);
			else
				send_gap(8'($urandom), 1'b1, 1'b0, gaps);
		end
		if (!byte_on_last || len == 0)
			send_gap(8'($urandom), 1'b0, 1'b1, gaps);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
	endtask

	initial begin
		int sent, len;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty message, bare requests, extremes, short messages
		send(8'hff, 1'b0, 1'b0);
		send(8'h00, 1'b0, 1'b1);
		send(8'h00, 1'b1, 1'b1);
		send(8'hff, 1'b1, 1'b0);
		send(8'h55, 1'b1, 1'b0);
		send(8'haa, 1'b1, 1'b1);
		for (int i = 0; i < 3; i++) send(8'h61 + 8'(i), 1'b1, i == 2);
		wait_drained();

		// pressure: receiver holds off while a message finishes, sender keeps going
		hold_sink = 1'b1;
		send_message(3, 1'b0, 1'b1);
		send_message(2, 1'b0, 1'b0);
		wait_drained();

		// sizes around the pad and block boundaries
		for (int l = 55; l <= 57; l++) send_message(l, 1'b1, l[0]);
		send_message(63, 1'b1, 1'b1);
		send_message(64, 1'b1, 1'b0);
		send_message(65, 1'b0, 1'b1);
		stall_free = 1'b1;
		send_message(16, 1'b0, 1'b1);
		stall_free = 1'b0;

		// random messages, mostly short
		sent = 0;
		while (sent < 80) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130)
				: $urandom_range(0, 20);
			send_message(len, $urandom_range(0, 1), $urandom_range(0, 1));
			sent += len + 1;
			if ($urandom_range(0, 9) == 0) wait_drained();
		end
		wait_drained();
		repeat (200) @(negedge clk);

		if (fail_count == 0 && words_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
